/* hdl/telnet_iac_stream_parser_assert.svh */
// ----------------------------------------------------------------------------
// Telnet IAC stream parser assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TELNET_IAC_STREAM_PARSER_ASSERT_SVH
`define TELNET_IAC_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold as well.
`define TISP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tisp: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define TISP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tisp: next-cycle check failed");

`endif

/* hdl/tisp_pkg.sv */
// ----------------------------------------------------------------------------
// Telnet IAC stream parser package
// Request and response types, parser phases and Telnet byte codes.
// ----------------------------------------------------------------------------
package tisp_pkg;

   // Saturation limits of the per-packet counters, at the width of their fields.
   localparam logic [10:0] DATA_CAP    = 11'd1024;
   localparam logic [6:0]  COMMAND_CAP = 7'd64;

   // Telnet byte codes.
   localparam logic [7:0] CODE_SE   = 8'd240;
   localparam logic [7:0] CODE_SB   = 8'd250;
   localparam logic [7:0] CODE_WILL = 8'd251;
   localparam logic [7:0] CODE_IAC  = 8'd255;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_DATA    = 2'd1,
      KIND_COMMAND = 2'd2
   } item_kind_type;

   typedef enum logic [2:0] {
      PH_DATA    = 3'd0,
      PH_IAC     = 3'd1,
      PH_OPTION  = 3'd2,
      PH_SUB     = 3'd3,
      PH_SUB_IAC = 3'd4,
      PH_HALT    = 3'd5
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      item_kind_type item_kind;
      logic [7:0]    data_byte;
      logic [7:0]    command_code;
      logic [7:0]    option_code;
      logic          option_present;
      logic          end_of_packet;
      logic          telnet_found;
      logic          parse_error;
      logic [10:0]   data_total;
      logic [6:0]    command_total;
   } rsp_type;

endpackage

/* hdl/tisp_in_stage.sv */
// ----------------------------------------------------------------------------
// Telnet IAC stream parser input stage
// Holds one accepted request until the parser moves it on.
// ----------------------------------------------------------------------------
module tisp_in_stage
   import tisp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    out_ready,
   output logic    advance,
   output req_type item
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type item_ff;
   logic    load;

   // The held request moves on whenever the result register can take it.
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign load      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (load) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_data;
      end
   end

   assign item = item_ff;

endmodule

/* hdl/tisp_parser.sv */
// ----------------------------------------------------------------------------
// Telnet IAC stream parser core
// Per-packet parser state, Telnet detector and the result of one byte.
// ----------------------------------------------------------------------------
module tisp_parser
   import tisp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   output rsp_type result
);

   parse_phase_type phase_ff,         phase_in;
   logic [7:0]      held_command_ff,  held_command_in;
   logic [10:0]     data_kept_ff,     data_kept_in;
   logic [6:0]      commands_kept_ff, commands_kept_in;
   logic            prev_iac_ff,      prev_iac_in;
   logic            detected_ff,      detected_in;
   logic            error_ff,         error_in;

   // State as seen by this byte: a first byte starts from the cleared state.
   parse_phase_type cur_phase;
   logic [7:0]      cur_held;
   logic [10:0]     cur_data_kept;
   logic [6:0]      cur_commands_kept;
   logic            cur_prev_iac;
   logic            cur_detected;
   logic            cur_error;

   // State after this byte, before the end-of-packet clear.
   parse_phase_type phase_nxt;
   logic [7:0]      held_nxt;
   logic [10:0]     data_kept_nxt;
   logic [6:0]      commands_kept_nxt;
   logic            detected_nxt;
   logic            error_nxt;
   logic            bad_command;

   item_kind_type   kind;
   logic [7:0]      data_byte;
   logic [7:0]      command_code;
   logic [7:0]      option_code;
   logic            option_present;

   logic [7:0]      b;
   logic            b_is_cmd;
   logic            data_room;
   logic            command_room;

   assign b        = item.byte_in;
   assign b_is_cmd = (b >= CODE_SE);

   always_comb begin
      if (item.first_byte) begin
         cur_phase         = PH_DATA;
         cur_held          = 8'd0;
         cur_data_kept     = 11'd0;
         cur_commands_kept = 7'd0;
         cur_prev_iac      = 1'b0;
         cur_detected      = 1'b0;
         cur_error         = 1'b0;
      end else begin
         cur_phase         = phase_ff;
         cur_held          = held_command_ff;
         cur_data_kept     = data_kept_ff;
         cur_commands_kept = commands_kept_ff;
         cur_prev_iac      = prev_iac_ff;
         cur_detected      = detected_ff;
         cur_error         = error_ff;
      end
   end

   assign data_room    = (cur_data_kept < DATA_CAP);
   assign command_room = (cur_commands_kept < COMMAND_CAP);

   // Next phase.
   always_comb begin
      phase_nxt   = cur_phase;
      held_nxt    = cur_held;
      bad_command = 1'b0;
      unique case (cur_phase)
         PH_DATA: begin
            if (b == CODE_IAC) begin
               phase_nxt = PH_IAC;
            end
         end
         PH_IAC: begin
            priority if (b == CODE_IAC) begin
               phase_nxt = PH_DATA;
            end else if (b >= CODE_WILL) begin
               held_nxt  = b;
               phase_nxt = PH_OPTION;
            end else if (b == CODE_SB) begin
               phase_nxt = PH_SUB;
            end else if (b_is_cmd) begin
               phase_nxt = PH_DATA;
            end else begin
               bad_command = 1'b1;
               phase_nxt   = PH_HALT;
            end
         end
         PH_OPTION: begin
            phase_nxt = PH_DATA;
         end
         PH_SUB: begin
            if (b == CODE_IAC) begin
               phase_nxt = PH_SUB_IAC;
            end
         end
         PH_SUB_IAC: begin
            priority if (b == CODE_SE) begin
               phase_nxt = PH_DATA;
            end else if (b != CODE_IAC) begin
               phase_nxt = PH_SUB;
            end else begin
               phase_nxt = PH_SUB_IAC;
            end
         end
         PH_HALT: begin
            phase_nxt = PH_HALT;
         end
         default: begin
            phase_nxt = PH_HALT;
         end
      endcase
   end

   // Result item of this byte.
   always_comb begin
      kind           = KIND_NONE;
      data_byte      = 8'd0;
      command_code   = 8'd0;
      option_code    = 8'd0;
      option_present = 1'b0;
      unique case (cur_phase)
         PH_DATA: begin
            if (b != CODE_IAC && data_room) begin
               kind      = KIND_DATA;
               data_byte = b;
            end
         end
         PH_IAC: begin
            priority if (b == CODE_IAC) begin
               if (data_room) begin
                  kind      = KIND_DATA;
                  data_byte = CODE_IAC;
               end
            end else if (b_is_cmd && b < CODE_SB) begin
               if (command_room) begin
                  kind         = KIND_COMMAND;
                  command_code = b;
               end
            end else begin
               kind = KIND_NONE;
            end
         end
         PH_OPTION: begin
            if (command_room) begin
               kind           = KIND_COMMAND;
               command_code   = cur_held;
               option_code    = b;
               option_present = 1'b1;
            end
         end
         default: begin
            kind = KIND_NONE;
         end
      endcase
   end

   assign data_kept_nxt     = cur_data_kept + 11'((kind == KIND_DATA) ? 1 : 0);
   assign commands_kept_nxt = cur_commands_kept + 7'((kind == KIND_COMMAND) ? 1 : 0);
   assign detected_nxt      = cur_detected || (cur_prev_iac && b_is_cmd);
   assign error_nxt         = cur_error || bad_command ||
                              (item.last_byte && (phase_nxt == PH_IAC ||
                                                  phase_nxt == PH_OPTION ||
                                                  phase_nxt == PH_SUB_IAC));

   always_comb begin
      result.item_kind      = kind;
      result.data_byte      = data_byte;
      result.command_code   = command_code;
      result.option_code    = option_code;
      result.option_present = option_present;
      result.end_of_packet  = item.last_byte;
      result.telnet_found   = detected_nxt;
      result.parse_error    = error_nxt;
      result.data_total     = data_kept_nxt;
      result.command_total  = commands_kept_nxt;
   end

   // The last byte of a packet leaves the cleared state behind it.
   always_comb begin
      if (item.last_byte) begin
         phase_in         = PH_DATA;
         held_command_in  = 8'd0;
         data_kept_in     = 11'd0;
         commands_kept_in = 7'd0;
         prev_iac_in      = 1'b0;
         detected_in      = 1'b0;
         error_in         = 1'b0;
      end else begin
         phase_in         = phase_nxt;
         held_command_in  = held_nxt;
         data_kept_in     = data_kept_nxt;
         commands_kept_in = commands_kept_nxt;
         prev_iac_in      = (b == CODE_IAC);
         detected_in      = detected_nxt;
         error_in         = error_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_DATA;
         held_command_ff  <= 8'd0;
         data_kept_ff     <= 11'd0;
         commands_kept_ff <= 7'd0;
         prev_iac_ff      <= 1'b0;
         detected_ff      <= 1'b0;
         error_ff         <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         held_command_ff  <= held_command_in;
         data_kept_ff     <= data_kept_in;
         commands_kept_ff <= commands_kept_in;
         prev_iac_ff      <= prev_iac_in;
         detected_ff      <= detected_in;
         error_ff         <= error_in;
      end
   end

endmodule

/* hdl/tisp_out_stage.sv */
// ----------------------------------------------------------------------------
// Telnet IAC stream parser output stage
// Result register that holds a response until the consumer takes it.
// ----------------------------------------------------------------------------
module tisp_out_stage
   import tisp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  rsp_type result,
   output logic    out_ready,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type rsp_ff;

   // Free when empty or when the held response leaves in this cycle.
   assign out_ready    = !out_valid_ff || !rsp_stall;
   assign out_valid_in = out_ready ? advance : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/telnet_iac_stream_parser.sv */
// ----------------------------------------------------------------------------
// Telnet IAC stream parser
// Parses packet payload bytes into data bytes and Telnet commands.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                        Moves
//  -------  ---------------------------  -------------------------------------
//  req      req_valid req_stall req_data one payload byte with packet marks
//  rsp      rsp_valid rsp_stall rsp_data one result for every request
//
// A request accepted into the input register is parsed and captured in the
// result register once that register has room, which then offers its response;
// one byte is taken in every cycle while rsp is not stalled. Reset clears both
// valid flags and the parser state; a first byte and the end of a last byte
// clear the parser as well. A stall on rsp holds the result register, and req
// is stalled only while the input register is full and cannot move on.
//
// The parser follows the byte after IAC: IAC IAC gives a data byte 255,
// WILL, WONT, DO and DONT wait for their option byte, codes 240 to 249 are
// commands on their own, and SB skips everything up to the next IAC SE. A
// code below 240 after IAC is an error, and the rest of that packet then
// yields empty responses. A packet that ends in the middle of a command is
// flagged as an error on its last response. Data and command responses stop
// once their counts reach their caps. Independently, a detector watches the
// raw bytes for IAC followed by 240 to 255 and reports it as telnet_found.
// ----------------------------------------------------------------------------
`include "telnet_iac_stream_parser_assert.svh"

module telnet_iac_stream_parser
   import tisp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    out_ready;
   logic    advance;
   req_type item;
   rsp_type result;

   // Input register: holds the accepted request until the result register
   // has room for its response.
   tisp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_ready (out_ready),
      .advance   (advance),
      .item      (item)
   );

   // Parser state and the combinational step of one byte; the state is
   // updated only when the request moves into the result register.
   tisp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   // Result register towards the consumer.
   tisp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A request is stalled only while the result register has no room.
   `TISP_ASSERT_IMP(a_stall_needs_held_request, req_stall, !out_ready)

   // A request that moves into the result register is offered next cycle.
   `TISP_ASSERT_NEXT(a_advance_gives_response, advance, rsp_valid)

   // The saturating counts never pass their caps.
   `TISP_ASSERT_IMP(a_counts_capped, rsp_valid,
      rsp_data.data_total <= DATA_CAP && rsp_data.command_total <= COMMAND_CAP)

   // An option byte is only ever reported with a command.
   `TISP_ASSERT_IMP(a_option_with_command, rsp_valid && rsp_data.option_present,
      rsp_data.item_kind == KIND_COMMAND && rsp_data.command_code >= CODE_WILL)

endmodule

/* test/telnet_iac_stream_parser_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet IAC stream parser checker
// Watches both channels, predicts each response from the accepted requests
// and compares the two field by field.
// ----------------------------------------------------------------------------
module telnet_iac_stream_parser_checker
   import tisp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      failures,
   output int      outstanding
);

   parse_phase_type phase;
   logic [7:0]      negotiation_verb;
   logic [10:0]     data_count;
   logic [6:0]      commands_counted;
   logic            prior_iac;
   logic            telnet_seen;
   logic            error_seen;

   rsp_type expected_results[$];
   int      fail_tally;
   int      results_seen;

   function automatic void clear_parser();
      phase            = PH_DATA;
      negotiation_verb = '0;
      data_count       = '0;
      commands_counted = '0;
      prior_iac        = 1'b0;
      telnet_seen      = 1'b0;
      error_seen       = 1'b0;
   endfunction

   // Works out the response to one payload byte and advances the parser.
   function automatic rsp_type parse_byte(input req_type r);
      rsp_type    res;
      logic [7:0] b;
      res = '0;
      b   = r.byte_in;
      if (r.first_byte) begin
         clear_parser();
      end
      // The detector looks at raw bytes, whatever the parser is doing.
      if (prior_iac && b >= CODE_SE) begin
         telnet_seen = 1'b1;
      end
      prior_iac = (b == CODE_IAC);
      case (phase)
         PH_DATA: begin
            if (b == CODE_IAC) begin
               phase = PH_IAC;
            end else if (data_count < DATA_CAP) begin
               data_count++;
               res.item_kind = KIND_DATA;
               res.data_byte = b;
            end
         end
         PH_IAC: begin
            if (b == CODE_IAC) begin
               phase = PH_DATA;
               if (data_count < DATA_CAP) begin
                  data_count++;
                  res.item_kind = KIND_DATA;
                  res.data_byte = CODE_IAC;
               end
            end else if (b >= CODE_WILL) begin
               negotiation_verb = b;
               phase = PH_OPTION;
            end else if (b == CODE_SB) begin
               phase = PH_SUB;
            end else if (b >= CODE_SE) begin
               phase = PH_DATA;
               if (commands_counted < COMMAND_CAP) begin
                  commands_counted++;
                  res.item_kind    = KIND_COMMAND;
                  res.command_code = b;
               end
            end else begin
               error_seen = 1'b1;
               phase      = PH_HALT;
            end
         end
         PH_OPTION: begin
            phase = PH_DATA;
            if (commands_counted < COMMAND_CAP) begin
               commands_counted++;
               res.item_kind      = KIND_COMMAND;
               res.command_code   = negotiation_verb;
               res.option_code    = b;
               res.option_present = 1'b1;
            end
         end
         PH_SUB: begin
            if (b == CODE_IAC) begin
               phase = PH_SUB_IAC;
            end
         end
         PH_SUB_IAC: begin
            if (b == CODE_SE) begin
               phase = PH_DATA;
            end else if (b != CODE_IAC) begin
               phase = PH_SUB;
            end
         end
         default: begin
            phase = PH_HALT;
         end
      endcase
      // A packet that stops in the middle of a command is an error.
      if (r.last_byte && (phase == PH_IAC || phase == PH_OPTION || phase == PH_SUB_IAC)) begin
         error_seen = 1'b1;
      end
      res.end_of_packet = r.last_byte;
      res.telnet_found  = telnet_seen;
      res.parse_error   = error_seen;
      res.data_total    = data_count;
      res.command_total = commands_counted;
      if (r.last_byte) begin
         clear_parser();
      end
      return res;
   endfunction

   function automatic bit field_matches(input string name, input logic [31:0] want,
                                        input logic [31:0] got, input bit show);
      if (want !== got && show) begin
         $display("ERROR: response %0d field %s expected %0d got %0d",
                  results_seen, name, want, got);
      end
      return want === got;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      bit      ok;
      bit      show;
      if (reset) begin
         clear_parser();
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(parse_byte(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            show = (fail_tally < 10);
            if (expected_results.size() == 0) begin
               if (show) begin
                  $display("ERROR: response %0d arrived with no request waiting", results_seen);
               end
               fail_tally++;
            end else begin
               want = expected_results.pop_front();
               ok = 1'b1;
               ok &= field_matches("item_kind", want.item_kind, rsp_data.item_kind, show);
               ok &= field_matches("data_byte", want.data_byte, rsp_data.data_byte, show);
               ok &= field_matches("command_code", want.command_code,
                                   rsp_data.command_code, show);
               ok &= field_matches("option_code", want.option_code,
                                   rsp_data.option_code, show);
               ok &= field_matches("option_present", want.option_present,
                                   rsp_data.option_present, show);
               ok &= field_matches("end_of_packet", want.end_of_packet,
                                   rsp_data.end_of_packet, show);
               ok &= field_matches("telnet_found", want.telnet_found,
                                   rsp_data.telnet_found, show);
               ok &= field_matches("parse_error", want.parse_error,
                                   rsp_data.parse_error, show);
               ok &= field_matches("data_total", want.data_total, rsp_data.data_total, show);
               ok &= field_matches("command_total", want.command_total,
                                   rsp_data.command_total, show);
               if (!ok) begin
                  fail_tally++;
               end
            end
            results_seen++;
         end
      end
      failures    <= fail_tally;
      outstanding <= expected_results.size();
   end

endmodule

/* test/tb_telnet_iac_stream_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet IAC stream parser testbench
// Drives packets of payload bytes into the parser, from short hand-picked
// sequences to random packets and one packet long enough to hit both caps,
// with random idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_telnet_iac_stream_parser;
   import tisp_pkg::*;

   // Telnet codes that the package does not name.
   localparam logic [7:0] CODE_GA   = 8'd249;
   localparam logic [7:0] CODE_DONT = 8'd254;

   // Number of requests sent before the long capped packet, the opening
   // packets included, and the length of the long response hold-off that
   // fills the parser's pipeline.
   localparam int RANDOM_ITEMS = 120;
   localparam int LONG_HOLD    = 200;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      failures;
   int      outstanding;

   // Controls shared between the request and response processes.
   bit idle_on      = 1'b0;
   bit hold_request = 1'b0;
   int sent_count   = 0;

   telnet_iac_stream_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   telnet_iac_stream_parser_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #6 clock = ~clock;
      end
   end

   // The run is far shorter than this even with the heaviest idling; reaching
   // it means that the handshake has hung.
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Offers one request and returns at the clock edge at which it is taken.
   // A random gap may come first while idling is enabled; the valid decision
   // never looks at the stall.
   task automatic send_request(input logic [7:0] value, input bit first, input bit last);
      req_type r;
      int      gap;
      r.byte_in    = value;
      r.first_byte = first;
      r.last_byte  = last;
      if (idle_on && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // Builds one short packet out of well-formed Telnet sequences with random
   // content, with some noise, bad commands and packets cut off mid-command.
   // A fifth of the packets carry plain data only, as non-Telnet traffic does.
   task automatic send_packet();
      logic [7:0] body[$];
      int         target;
      int         choice;
      int         inner;
      bit         plain;
      bit         mark_first;
      bit         mark_last;
      target = ($urandom_range(0, 15) == 0) ? 1 : $urandom_range(2, 20);
      plain  = ($urandom_range(0, 4) == 0);
      while (body.size() < target) begin
         choice = plain ? 0 : $urandom_range(0, 99);
         if (choice < 50) begin
            body.push_back(8'($urandom_range(0, CODE_IAC - 1)));
         end else if (choice < 58) begin
            body.push_back(CODE_IAC);
            body.push_back(CODE_IAC);
         end else if (choice < 70) begin
            body.push_back(CODE_IAC);
            body.push_back(8'($urandom_range(CODE_WILL, CODE_DONT)));
            body.push_back(8'($urandom));
         end else if (choice < 80) begin
            body.push_back(CODE_IAC);
            body.push_back(8'($urandom_range(CODE_SE, CODE_GA)));
         end else if (choice < 88) begin
            // Subnegotiation with escaped and stray IACs inside, usually closed.
            body.push_back(CODE_IAC);
            body.push_back(CODE_SB);
            inner = $urandom_range(0, 4);
            repeat (inner) begin
               case ($urandom_range(0, 2))
                  0: begin
                     body.push_back(8'($urandom_range(0, CODE_IAC - 1)));
                  end
                  1: begin
                     body.push_back(CODE_IAC);
                     body.push_back(CODE_IAC);
                  end
                  default: begin
                     body.push_back(CODE_IAC);
                     body.push_back(8'($urandom_range(0, CODE_SE - 1)));
                  end
               endcase
            end
            if ($urandom_range(0, 9) != 0) begin
               body.push_back(CODE_IAC);
               body.push_back(CODE_SE);
            end
         end else if (choice < 91) begin
            body.push_back(CODE_IAC);
            body.push_back(8'($urandom_range(0, CODE_SE - 1)));
         end else begin
            body.push_back(8'($urandom));
         end
      end
      // Some packets end half way through a sequence.
      if (!plain) begin
         case ($urandom_range(0, 9))
            0: begin
               body.push_back(CODE_IAC);
            end
            1: begin
               body.push_back(CODE_IAC);
               body.push_back(8'($urandom_range(CODE_WILL, CODE_DONT)));
            end
            2: begin
               body.push_back(CODE_IAC);
               body.push_back(CODE_SB);
               body.push_back(8'($urandom));
            end
            3: begin
               body.push_back(CODE_IAC);
               body.push_back(CODE_SB);
               body.push_back(8'($urandom_range(0, CODE_IAC - 1)));
               body.push_back(CODE_IAC);
            end
            default: begin
            end
         endcase
      end
      // Marks are left off now and then, and a stray first mark may restart
      // the parser in the middle of a packet.
      mark_first = ($urandom_range(0, 7) != 0);
      mark_last  = ($urandom_range(0, 9) != 0);
      foreach (body[i]) begin
         send_request(body[i],
                      (i == 0 && mark_first) || (i > 0 && $urandom_range(0, 39) == 0),
                      (i == body.size() - 1) && mark_last);
      end
   endtask

   // One packet with more data bytes and commands than the caps allow, so
   // that responses beyond either cap come out empty while the totals hold.
   // Mostly data, with a command after every fourteen data bytes.
   task automatic send_capped_packet();
      int data_sent;
      int commands_sent;
      int step;
      data_sent     = 1;
      commands_sent = 0;
      step          = 0;
      send_request(8'($urandom_range(0, CODE_IAC - 1)), 1'b1, 1'b0);
      while (data_sent < DATA_CAP + 4 || commands_sent < COMMAND_CAP + 4) begin
         step++;
         if (step % 15 == 0) begin
            send_request(CODE_IAC, 1'b0, 1'b0);
            if (commands_sent % 2 == 0) begin
               send_request(8'($urandom_range(CODE_SE, CODE_GA)), 1'b0, 1'b0);
            end else begin
               send_request(8'($urandom_range(CODE_WILL, CODE_DONT)), 1'b0, 1'b0);
               send_request(8'($urandom), 1'b0, 1'b0);
            end
            commands_sent++;
         end else if (step % 50 == 7) begin
            send_request(CODE_IAC, 1'b0, 1'b0);
            send_request(CODE_IAC, 1'b0, 1'b0);
            data_sent++;
         end else begin
            send_request(8'($urandom_range(0, CODE_IAC - 1)), 1'b0, 1'b0);
            data_sent++;
         end
      end
      send_request(8'($urandom_range(0, CODE_IAC - 1)), 1'b0, 1'b1);
   endtask

   // Response side: random stall bursts while idling is enabled, and one long
   // hold-off on request, counted here in cycles, during which the request
   // side keeps offering bytes until the parser stalls its input.
   initial begin
      int burst;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 15);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;

      // Hand-picked opening packet: data at both ends of the range, an escaped
      // IAC, DONT with option 255, SE and GA as commands on their own, and a
      // subnegotiation holding an escaped IAC and a stray IAC before its SE.
      // It ends on a lone IAC, which is a truncated sequence.
      send_request(8'd0,      1'b1, 1'b0);
      send_request(CODE_DONT, 1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b0);
      send_request(CODE_DONT, 1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b0);
      send_request(CODE_SE,   1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b0);
      send_request(CODE_GA,   1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b0);
      send_request(CODE_SB,   1'b0, 1'b0);
      send_request(8'd24,     1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b0);
      send_request(8'd1,      1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b0);
      send_request(CODE_SE,   1'b0, 1'b0);
      send_request(CODE_IAC,  1'b0, 1'b1);
      // A packet without a first mark that starts with a bad command: the
      // parser halts and the data byte after it is ignored.
      send_request(CODE_IAC,        1'b0, 1'b0);
      send_request(CODE_SE - 8'd1,  1'b0, 1'b0);
      send_request(8'd65,           1'b0, 1'b1);
      // A packet of a single byte carrying both marks.
      send_request(CODE_WILL, 1'b1, 1'b1);

      while (sent_count < RANDOM_ITEMS / 2) send_packet();

      // Let the parser drain completely before going on.
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);

      hold_request = 1'b1;
      while (sent_count < RANDOM_ITEMS) send_packet();

      // The last part runs at full rate on both channels.
      idle_on = 1'b0;
      send_capped_packet();
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* telnet_iac_stream_parser.f */
+incdir+hdl
hdl/tisp_pkg.sv
hdl/tisp_in_stage.sv
hdl/tisp_parser.sv
hdl/tisp_out_stage.sv
hdl/telnet_iac_stream_parser.sv
test/telnet_iac_stream_parser_checker.sv
test/tb_telnet_iac_stream_parser.sv
